### hdl/gsst_pkg.sv
package gsst_pkg;

    localparam int TIME_W  = 64;
    localparam int COUNT_W = 10;
    localparam int RAW_W   = 16;
    localparam int FINE_W  = 4;
    localparam int AXIS_W  = RAW_W + FINE_W;
    localparam int FACT_W  = 11;
    localparam int PROD_W  = 32;
    localparam int RATE_W  = 31;

    localparam int unsigned MAX_FRAMES  = 1023;
    localparam int          QUEUE_DEPTH = 2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 168;

    localparam int S_TIME_LO  = 0;
    localparam int S_COUNT_LO = S_TIME_LO + TIME_W;
    localparam int S_GX_LO    = S_COUNT_LO + COUNT_W;
    localparam int S_GY_LO    = S_GX_LO + RAW_W;
    localparam int S_GZ_LO    = S_GY_LO + RAW_W;
    localparam int S_FX_LO    = S_GZ_LO + RAW_W;
    localparam int S_FY_LO    = S_FX_LO + FINE_W;
    localparam int S_FZ_LO    = S_FY_LO + FINE_W;
    localparam int S_USED_W   = S_FZ_LO + FINE_W;

    localparam int M_STAMP_LO = 0;
    localparam int M_RX_LO    = M_STAMP_LO + TIME_W;
    localparam int M_RY_LO    = M_RX_LO + RATE_W;
    localparam int M_RZ_LO    = M_RY_LO + RATE_W;
    localparam int M_COUNT_LO = M_RZ_LO + RATE_W;
    localparam int M_USED_W   = M_COUNT_LO + COUNT_W;

    localparam logic [1:0] CMD_ARM    = 2'd0;
    localparam logic [1:0] CMD_BATCH  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic CFG_HIRES = 1'b0;
    localparam logic CFG_RANGE = 1'b1;

    localparam logic [1:0] RANGE_2000DPS = 2'd0;
    localparam logic [1:0] RANGE_1000DPS = 2'd1;
    localparam logic [1:0] RANGE_500DPS  = 2'd2;
    localparam logic [1:0] RANGE_250DPS  = 2'd3;

    localparam logic [FACT_W-1:0] FACTOR_2000DPS = 11'd1065;
    localparam logic [FACT_W-1:0] FACTOR_1000DPS = 11'd532;
    localparam logic [FACT_W-1:0] FACTOR_500DPS  = 11'd267;
    localparam logic [FACT_W-1:0] FACTOR_250DPS  = 11'd133;

    typedef enum logic [1:0] {
        OP_ARM,
        OP_BATCH,
        OP_SAMPLE
    } t_op;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_REPORT
    } t_back_state;

    typedef struct packed {
        logic       hires_enable;
        logic [1:0] gyro_range;
    } t_cfg;

    typedef struct packed {
        t_op                      op;
        logic [TIME_W-1:0]        time_us;
        logic [COUNT_W-1:0]       count;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
    } t_item;

    function automatic logic [FACT_W-1:0] range_factor(input logic [1:0] sel);
        logic [FACT_W-1:0] f;
        unique case (sel)
            RANGE_2000DPS: f = FACTOR_2000DPS;
            RANGE_1000DPS: f = FACTOR_1000DPS;
            RANGE_500DPS:  f = FACTOR_500DPS;
            RANGE_250DPS:  f = FACTOR_250DPS;
            default:       f = FACTOR_2000DPS;
        endcase
        return f;
    endfunction

endpackage

### hdl/gsst_front.sv
module gsst_front
    import gsst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_hires_enable,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [1:0]           i_tuser,
    input  logic [S_TDATA_W-1:0] i_tdata,
    output logic                 o_push,
    output t_item                o_item,
    input  logic                 i_q_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  n_keep;
    logic  w_accept;

    function automatic logic signed [AXIS_W-1:0] join_axis(
        input logic [RAW_W-1:0]  raw,
        input logic [FINE_W-1:0] fine,
        input logic              hires
    );
        logic signed [AXIS_W-1:0] v;
        if (hires) begin
            v = {raw, fine};
        end else begin
            v = {{FINE_W{raw[RAW_W-1]}}, raw};
        end
        return v;
    endfunction

    always_comb begin
        n_item.time_us = i_tdata[S_TIME_LO +: TIME_W];
        n_item.count   = i_tdata[S_COUNT_LO +: COUNT_W];
        if (32'(n_item.count) > MAX_FRAMES) begin
            n_item.count = COUNT_W'(MAX_FRAMES);
        end
        n_item.axis_x = join_axis(i_tdata[S_GX_LO +: RAW_W], i_tdata[S_FX_LO +: FINE_W],
                                  i_hires_enable);
        n_item.axis_y = join_axis(i_tdata[S_GY_LO +: RAW_W], i_tdata[S_FY_LO +: FINE_W],
                                  i_hires_enable);
        n_item.axis_z = join_axis(i_tdata[S_GZ_LO +: RAW_W], i_tdata[S_FZ_LO +: FINE_W],
                                  i_hires_enable);
        n_item.op = OP_SAMPLE;
        n_keep    = 1'b0;
        unique case (i_tuser)
            CMD_ARM: begin
                n_item.op = OP_ARM;
                n_keep    = 1'b1;
            end
            CMD_BATCH: begin
                n_item.op = OP_BATCH;
                n_keep    = (n_item.count != '0);
            end
            CMD_SAMPLE: begin
                n_item.op = OP_SAMPLE;
                n_keep    = 1'b1;
            end
            default: begin
                n_keep = 1'b0;
            end
        endcase
    end

    assign o_tready = !r_valid || i_q_ready;
    assign w_accept = i_tvalid && o_tready;
    assign o_push   = r_valid;
    assign o_item   = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= n_keep;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

endmodule

### hdl/gsst_queue.sv
module gsst_queue
    import gsst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/gsst_back.sv
module gsst_back
    import gsst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_gyro_range,
    input  logic                 i_q_valid,
    input  t_item                i_q_item,
    output logic                 o_q_pop,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic                 o_tuser,
    output logic [M_TDATA_W-1:0] o_tdata
);

    localparam int DIV_STEPS = TIME_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

    t_back_state r_state;
    t_back_state n_state;

    logic [TIME_W-1:0]  r_last_sync;
    logic [TIME_W-1:0]  r_batch_start;
    logic [TIME_W-1:0]  r_step;
    logic [TIME_W-1:0]  r_running;
    logic               r_fresh;
    logic               r_first_seen;
    logic               r_deliver;

    logic [COUNT_W-1:0] r_rep_count;
    logic [COUNT_W-1:0] r_den;
    logic [COUNT_W-1:0] r_rem;
    logic [TIME_W-1:0]  r_quo;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [COUNT_W:0]   w_trial;
    logic               w_fit;
    logic [COUNT_W-1:0] n_rem;
    logic [TIME_W-1:0]  n_quo;

    logic               r_out_valid;
    logic               r_out_kind;
    logic [TIME_W-1:0]  r_out_stamp;
    logic [RATE_W-1:0]  r_out_rx;
    logic [RATE_W-1:0]  r_out_ry;
    logic [RATE_W-1:0]  r_out_rz;
    logic [COUNT_W-1:0] r_out_count;

    logic               w_out_free;
    logic               w_pop;
    logic               w_load;
    logic               w_load_report;
    logic [TIME_W-1:0]  n_running;
    logic [FACT_W-1:0]  w_factor;
    logic signed [PROD_W-1:0] w_px;
    logic signed [PROD_W-1:0] w_py;
    logic signed [PROD_W-1:0] w_pz;

    assign w_out_free = !r_out_valid || i_tready;
    assign n_running  = r_fresh ? r_batch_start : r_running + r_step;
    assign w_factor   = range_factor(i_gyro_range);
    assign w_px = $signed(i_q_item.axis_x) * $signed({1'b0, w_factor});
    assign w_py = $signed(i_q_item.axis_y) * $signed({1'b0, w_factor});
    assign w_pz = $signed(i_q_item.axis_z) * $signed({1'b0, w_factor});

    assign w_trial = {r_rem, r_quo[TIME_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign n_rem   = w_fit ? COUNT_W'(w_trial - {1'b0, r_den}) : w_trial[COUNT_W-1:0];
    assign n_quo   = {r_quo[TIME_W-2:0], w_fit};

    always_comb begin
        n_state       = r_state;
        w_pop         = 1'b0;
        w_load        = 1'b0;
        w_load_report = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_item.op)
                        OP_ARM: begin
                            w_pop = 1'b1;
                        end
                        OP_BATCH: begin
                            w_pop   = 1'b1;
                            n_state = BK_DIV;
                        end
                        OP_SAMPLE: begin
                            if (!r_deliver || w_out_free) begin
                                w_pop  = 1'b1;
                                w_load = r_deliver;
                            end
                        end
                        default: begin
                            w_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_DIV: begin
                if (r_dcnt == DIV_LAST) begin
                    n_state = BK_REPORT;
                end
            end
            BK_REPORT: begin
                if (w_out_free) begin
                    w_load        = 1'b1;
                    w_load_report = 1'b1;
                    n_state       = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_q_pop = w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_last_sync   <= '0;
            r_batch_start <= '0;
            r_step        <= '0;
            r_running     <= '0;
            r_fresh       <= 1'b0;
            r_first_seen  <= 1'b0;
            r_deliver     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_pop) begin
                unique case (i_q_item.op)
                    OP_ARM: begin
                        r_last_sync   <= i_q_item.time_us;
                        r_batch_start <= i_q_item.time_us;
                        r_fresh       <= 1'b1;
                    end
                    OP_BATCH: begin
                        r_batch_start <= r_last_sync;
                        r_last_sync   <= i_q_item.time_us;
                        r_fresh       <= 1'b1;
                        r_deliver     <= r_first_seen;
                        r_first_seen  <= 1'b1;
                    end
                    OP_SAMPLE: begin
                        r_running <= n_running;
                        r_fresh   <= 1'b0;
                    end
                    default: begin
                        r_fresh <= r_fresh;
                    end
                endcase
            end
            if (w_load_report) begin
                r_step <= r_quo;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && i_q_item.op == OP_BATCH) begin
            r_rep_count <= r_first_seen ? i_q_item.count : '0;
            r_den       <= i_q_item.count;
            r_rem       <= '0;
            r_quo       <= i_q_item.time_us - r_last_sync;
            r_dcnt      <= '0;
        end else if (r_state == BK_DIV) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (w_load) begin
            if (w_load_report) begin
                r_out_kind  <= KIND_REPORT;
                r_out_stamp <= '0;
                r_out_rx    <= '0;
                r_out_ry    <= '0;
                r_out_rz    <= '0;
                r_out_count <= r_rep_count;
            end else begin
                r_out_kind  <= KIND_SAMPLE;
                r_out_stamp <= n_running;
                r_out_rx    <= w_px[RATE_W-1:0];
                r_out_ry    <= w_py[RATE_W-1:0];
                r_out_rz    <= w_pz[RATE_W-1:0];
                r_out_count <= '0;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tuser  = r_out_kind;
    assign o_tdata  = {(M_TDATA_W - M_USED_W)'(0), r_out_count, r_out_rz, r_out_ry,
                       r_out_rx, r_out_stamp};

endmodule

### hdl/gyro_sample_scale_timestamp.sv
// Gyroscope frame scaler and timestamper.
// Input words arrive on the s_axis group: tuser carries the command (arm, batch
// sync, sample), tdata the time, frame count, raw axes and fine bits. Result
// words leave on the m_axis group: tuser is the kind (sample or batch report),
// tdata the stamp, three rates in urad/s (hires: 1/16 urad/s), reported count.
// Configuration is written through i_cfg_wen/i_cfg_addr/i_cfg_data while idle:
// address 0 enables high-resolution axes, address 1 selects the full scale.
// A word passes a front register, a two-entry queue and the back end's result
// register in that order. The back end pops arm and sample words while idle,
// a sample to be delivered waiting for a free result register. A batch word
// holds the back end while the bit-serial 64-bit divider forms the per-frame
// step and the report goes out; the queue takes words meanwhile until full.
// Synchronous reset clears all timing state and the configuration; frames of
// the first batch after reset are dropped and that batch reports a count of 0.
// When the receiver stalls, the result register holds its word, the back end
// waits, and the queue and front fill until s_axis tready falls.
module gyro_sample_scale_timestamp
    import gsst_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wen,
    input  logic                 i_cfg_addr,
    input  logic [1:0]           i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // cmd
    input  logic [1:0]           s_axis_tuser,
    // time_us, frame_count, gyro_x, gyro_y, gyro_z, fine_x, fine_y, fine_z
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // kind
    output logic                 m_axis_tuser,
    // stamp, rate_x, rate_y, rate_z, reported_count
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_cfg  r_cfg;
    logic  w_push;
    t_item w_push_item;
    logic  w_q_ready;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_addr)
                CFG_HIRES: r_cfg.hires_enable <= i_cfg_data[0];
                CFG_RANGE: r_cfg.gyro_range   <= i_cfg_data;
                default:   r_cfg              <= r_cfg;
            endcase
        end
    end

    gsst_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_hires_enable (r_cfg.hires_enable),
        .i_tvalid       (s_axis_tvalid),
        .o_tready       (s_axis_tready),
        .i_tuser        (s_axis_tuser),
        .i_tdata        (s_axis_tdata),
        .o_push         (w_push),
        .o_item         (w_push_item),
        .i_q_ready      (w_q_ready)
    );

    gsst_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_q_pop)
    );

    gsst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gyro_range (r_cfg.gyro_range),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_tvalid     (m_axis_tvalid),
        .i_tready     (m_axis_tready),
        .o_tuser      (m_axis_tuser),
        .o_tdata      (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    a_sample_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_SAMPLE)
            |-> (m_axis_tdata[M_COUNT_LO +: COUNT_W] == '0))
        else $error("sample word carries a count");

    a_report_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_REPORT)
            |-> (m_axis_tdata[M_STAMP_LO +: TIME_W] == '0
                 && 32'(m_axis_tdata[M_COUNT_LO +: COUNT_W]) <= MAX_FRAMES))
        else $error("batch report carries a stamp or an oversized count");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("back end popped an empty queue");
`endif

endmodule
